>>> rtl/segi_pkg.sv
// shared types and constants for the segment intersection pipeline
`default_nettype none
package segi_pkg;
    localparam int OUT_BITS = 32;

    typedef struct packed {
        logic is_parallel;
        logic is_coincident;
        logic is_intersecting;
    } flags_t;
endpackage
`default_nettype wire

>>> rtl/segi_div_cell.sv
// one restoring-division cell: retires one quotient bit per cycle for both axes while en is high
`default_nettype none
module segi_div_cell #(
    parameter int NB = 64,
    parameter int DB = 34,
    parameter int SHIFT = 0,
    parameter int WB = 80
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          vin,
    input  wire logic [WB-1:0] pin,
    input  wire logic [NB-1:0] nx_in,
    input  wire logic [NB-1:0] ny_in,
    input  wire logic [NB-1:0] qx_in,
    input  wire logic [NB-1:0] qy_in,
    input  wire logic [DB-1:0] den_in,
    output logic               vout,
    output logic [WB-1:0]      pout,
    output logic [NB-1:0]      nx_out,
    output logic [NB-1:0]      ny_out,
    output logic [NB-1:0]      qx_out,
    output logic [NB-1:0]      qy_out,
    output logic [DB-1:0]      den_out
);
    localparam int EB = NB + DB;
    logic [EB-1:0] dsh;
    logic          bx;
    logic          by;

    // divisor shifted up to this cell's quotient bit
    assign dsh = {{NB{1'b0}}, den_in} << SHIFT;
    assign bx  = {{DB{1'b0}}, nx_in} >= dsh;
    assign by  = {{DB{1'b0}}, ny_in} >= dsh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vout <= 1'b0;
        end
        else if (en)
        begin
            vout <= vin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pout    <= pin;
            den_out <= den_in;
            nx_out  <= bx ? nx_in - dsh[NB-1:0] : nx_in;
            ny_out  <= by ? ny_in - dsh[NB-1:0] : ny_in;
            qx_out  <= qx_in | (NB'(bx) << SHIFT);
            qy_out  <= qy_in | (NB'(by) << SHIFT);
        end
    end
endmodule
`default_nettype wire

>>> rtl/segment_intersection.sv
// segment intersection top level: cross products, range test and divider chain
//
// usage: each s_axis beat carries two segments as eight signed coordinates,
// and each m_axis beat returns the flags and the crossing point in fixed point
// with FRAC fraction bits. one result is produced for every input beat, in
// order.
// two stages form the cross products and range test, one stage forms the
// scaled numerators, one divider cell per quotient bit follows
// (QB = COORD_BITS+FRAC+2), and the output register closes the chain.
// throughput is one beat per cycle while m_axis does not stall. The divider
// chain has one cell per quotient bit, so a new pair can enter every cycle.
// a stall on m_axis freezes the whole chain, and s_axis_tready drops only
// while the output register holds a beat that has not been taken.
// reset clears every valid bit in the chain; payload registers need no reset.
`default_nettype none
module segment_intersection #(
    parameter int COORD_BITS = 16,
    parameter int FRAC = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  wire logic [8*COORD_BITS+((8-(8*COORD_BITS)%8)%8)-1:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // is_parallel, is_coincident, is_intersecting, cross_x, cross_y
    output logic [71:0]       m_axis_tdata
);
    localparam int C   = COORD_BITS;
    localparam int DLB = C + 1;
    localparam int PB  = 2 * C + 3;
    localparam int QB  = C + 1 + FRAC + 1;
    localparam int NB  = PB + DLB + FRAC;
    localparam int DB  = PB;
    localparam int WB  = 3 + 1 + 1 + 2 * (C + FRAC + 2);
    localparam int OB  = segi_pkg::OUT_BITS;
    localparam int SB  = C + FRAC + 2;

    logic adv;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    logic signed [C-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    assign ax1 = s_axis_tdata[0*C +: C];
    assign ay1 = s_axis_tdata[1*C +: C];
    assign ax2 = s_axis_tdata[2*C +: C];
    assign ay2 = s_axis_tdata[3*C +: C];
    assign bx1 = s_axis_tdata[4*C +: C];
    assign by1 = s_axis_tdata[5*C +: C];
    assign bx2 = s_axis_tdata[6*C +: C];
    assign by2 = s_axis_tdata[7*C +: C];

    // stage 1: deltas and products
    logic                  v1_reg;
    logic signed [DLB-1:0] dax_reg, day_reg;
    logic signed [C-1:0]   ax1_reg, ay1_reg;
    logic signed [PB-1:0]  p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [DLB-1:0] dax, day, dbx, dby, wx, wy;
    assign dax = DLB'(ax2) - DLB'(ax1);
    assign day = DLB'(ay2) - DLB'(ay1);
    assign dbx = DLB'(bx2) - DLB'(bx1);
    assign dby = DLB'(by2) - DLB'(by1);
    assign wx  = DLB'(ax1) - DLB'(bx1);
    assign wy  = DLB'(ay1) - DLB'(by1);

    // stage 2: cross products and tests
    logic                 v2_reg;
    logic                 neg2_reg;
    segi_pkg::flags_t     fl2_reg;
    logic signed [PB-1:0] na2_reg;
    logic [DB-1:0]        den2_reg;
    logic signed [DLB-1:0] dax2_reg, day2_reg;
    logic signed [C-1:0]  ax2_reg, ay2_reg;
    logic signed [PB-1:0] den_c, na_c, nb_c;
    logic                 ina, inb;
    assign den_c = p0_reg - p1_reg;
    assign na_c  = p2_reg - p3_reg;
    assign nb_c  = p4_reg - p5_reg;
    assign ina = den_c[PB-1] ? (na_c <= 0 && na_c >= den_c) : (na_c >= 0 && na_c <= den_c);
    assign inb = den_c[PB-1] ? (nb_c <= 0 && nb_c >= den_c) : (nb_c >= 0 && nb_c <= den_c);

    // stage 3: scaled numerator magnitudes
    logic                 v3_reg;
    logic [WB-1:0]        pl3_reg;
    logic [NB-1:0]        nx3_reg, ny3_reg;
    logic [DB-1:0]        den3_reg;
    logic [PB-1:0]        mna;
    logic [DLB-1:0]       mdx, mdy;
    logic [NB-1:0]        prx, pry;
    logic                 sgx, sgy;
    assign mna = na2_reg[PB-1] ? PB'(-na2_reg) : PB'(na2_reg);
    assign mdx = dax2_reg[DLB-1] ? DLB'(-dax2_reg) : DLB'(dax2_reg);
    assign mdy = day2_reg[DLB-1] ? DLB'(-day2_reg) : DLB'(day2_reg);
    assign prx = NB'(NB'(mna) * NB'(mdx)) << FRAC;
    assign pry = NB'(NB'(mna) * NB'(mdy)) << FRAC;
    assign sgx = na2_reg[PB-1] ^ dax2_reg[DLB-1] ^ neg2_reg;
    assign sgy = na2_reg[PB-1] ^ day2_reg[DLB-1] ^ neg2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dax_reg <= dax;
            day_reg <= day;
            ax1_reg <= ax1;
            ay1_reg <= ay1;
            p0_reg  <= PB'(dax) * PB'(dby);
            p1_reg  <= PB'(day) * PB'(dbx);
            p2_reg  <= PB'(dbx) * PB'(wy);
            p3_reg  <= PB'(dby) * PB'(wx);
            p4_reg  <= PB'(dax) * PB'(wy);
            p5_reg  <= PB'(day) * PB'(wx);
            fl2_reg.is_parallel     <= (den_c == 0) && !(na_c == 0 && nb_c == 0);
            fl2_reg.is_coincident   <= (den_c == 0) && (na_c == 0 && nb_c == 0);
            fl2_reg.is_intersecting <= (den_c != 0) && ina && inb;
            neg2_reg <= den_c[PB-1];
            den2_reg <= den_c[PB-1] ? DB'(-den_c) : DB'(den_c);
            na2_reg  <= na_c;
            dax2_reg <= dax_reg;
            day2_reg <= day_reg;
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
            pl3_reg  <= {fl2_reg, sgx, sgy, SB'(ax2_reg) <<< FRAC, SB'(ay2_reg) <<< FRAC};
            nx3_reg  <= fl2_reg.is_intersecting ? prx : '0;
            ny3_reg  <= fl2_reg.is_intersecting ? pry : '0;
            den3_reg <= (den2_reg == 0) ? DB'(1) : den2_reg;
        end
    end

    // divider chain, most significant quotient bit first
    logic [QB:0]         vc;
    logic [WB-1:0]       pc  [QB+1];
    logic [NB-1:0]       nxc [QB+1];
    logic [NB-1:0]       nyc [QB+1];
    logic [NB-1:0]       qxc [QB+1];
    logic [NB-1:0]       qyc [QB+1];
    logic [DB-1:0]       dc  [QB+1];

    assign vc[0]  = v3_reg;
    assign pc[0]  = pl3_reg;
    assign nxc[0] = nx3_reg;
    assign nyc[0] = ny3_reg;
    assign qxc[0] = '0;
    assign qyc[0] = '0;
    assign dc[0]  = den3_reg;

    genvar g;
    generate
        for (g = 0; g < QB; g++)
        begin : g_cell
            segi_div_cell #(.NB(NB), .DB(DB), .SHIFT(QB-1-g), .WB(WB)) u_cell (
                .clk(clk), .rst_n(rst_n), .en(adv), .vin(vc[g]),
                .pin(pc[g]), .nx_in(nxc[g]), .ny_in(nyc[g]), .qx_in(qxc[g]),
                .qy_in(qyc[g]), .den_in(dc[g]), .vout(vc[g+1]), .pout(pc[g+1]),
                .nx_out(nxc[g+1]), .ny_out(nyc[g+1]), .qx_out(qxc[g+1]),
                .qy_out(qyc[g+1]), .den_out(dc[g+1])
            );
        end
    endgenerate

    // final sum and saturation
    logic [WB-1:0]        pf;
    segi_pkg::flags_t     flf;
    logic signed [SB-1:0] bxs, bys;
    logic                 sx, sy;
    logic signed [SB+1:0] qxs, qys, rx, ry;
    logic signed [OB-1:0] ox, oy;
    assign pf  = pc[QB];
    assign flf = pf[WB-1 -: 3];
    assign sx  = pf[WB-4];
    assign sy  = pf[WB-5];
    assign bxs = pf[2*SB-1 -: SB];
    assign bys = pf[SB-1:0];
    assign qxs = sx ? -(SB+2)'(qxc[QB][QB-1:0]) : (SB+2)'(qxc[QB][QB-1:0]);
    assign qys = sy ? -(SB+2)'(qyc[QB][QB-1:0]) : (SB+2)'(qyc[QB][QB-1:0]);
    assign rx  = (SB+2)'(bxs) + qxs;
    assign ry  = (SB+2)'(bys) + qys;

    function automatic logic signed [OB-1:0] sat(input logic signed [SB+1:0] v);
        logic signed [SB+1:0] hi, lo;
        hi = (SB+2)'(64'sh7fffffff);
        lo = -(SB+2)'(64'sh7fffffff) - 1;
        if ((SB+2) <= OB)
            sat = OB'(v);
        else if (v > hi)
            sat = {1'b0, {(OB-1){1'b1}}};
        else if (v < lo)
            sat = {1'b1, {(OB-1){1'b0}}};
        else
            sat = OB'(v);
    endfunction

    assign ox = flf.is_intersecting ? sat(rx) : '0;
    assign oy = flf.is_intersecting ? sat(ry) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tvalid <= 1'b0;
        end
        else if (adv)
        begin
            m_axis_tvalid <= vc[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_axis_tdata <= {5'b0, oy, ox, flf.is_intersecting, flf.is_coincident,
                             flf.is_parallel};
        end
    end
endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// testbench for segment_intersection: directed and random segment pairs against a predictor
`default_nettype none
module tb;
    localparam int COORD_BITS = 16;
    localparam int FRAC       = 16;
    localparam int DRAIN      = 200;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct {
        segi_pkg::flags_t                     flags;
        logic signed [segi_pkg::OUT_BITS-1:0] cross_x;
        logic signed [segi_pkg::OUT_BITS-1:0] cross_y;
    } crossing_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // is_parallel, is_coincident, is_intersecting, cross_x, cross_y
    logic [71:0]  m_axis_tdata;

    crossing_t pending_crossings[$];
    int        error_count;
    int        cycle_count;
    int        send_idle_pct;
    int        recv_idle_pct;

    segment_intersection #(
        .COORD_BITS(COORD_BITS),
        .FRAC(FRAC)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // trunc(n * d * 2^FRAC / den), exact in 128 bits
    function automatic longint scaled_offset(longint n, longint d, longint den);
        logic signed [127:0] wn;
        logic signed [127:0] wd;
        logic signed [127:0] wden;
        logic signed [127:0] prod;
        wn   = 128'(n);
        wd   = 128'(d);
        wden = 128'(den);
        prod = (wn * wd) <<< FRAC;
        return longint'(prod / wden);
    endfunction

    function automatic logic signed [segi_pkg::OUT_BITS-1:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic in_unit(longint n, longint den);
        if (den > 0)
            return n >= 0 && n <= den;
        return n <= 0 && n >= den;
    endfunction

    function automatic crossing_t predict_crossing(coord_t pt[8]);
        crossing_t r;
        longint ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
        longint dax, day, dbx, dby, wx, wy, den, na, nb;
        ax1 = longint'(pt[0]); ay1 = longint'(pt[1]);
        ax2 = longint'(pt[2]); ay2 = longint'(pt[3]);
        bx1 = longint'(pt[4]); by1 = longint'(pt[5]);
        bx2 = longint'(pt[6]); by2 = longint'(pt[7]);
        dax = ax2 - ax1;
        day = ay2 - ay1;
        dbx = bx2 - bx1;
        dby = by2 - by1;
        wx  = ax1 - bx1;
        wy  = ay1 - by1;
        den = dax * dby - day * dbx;
        na  = dbx * wy - dby * wx;
        nb  = dax * wy - day * wx;
        r.flags   = '0;
        r.cross_x = '0;
        r.cross_y = '0;
        if (den == 0)
        begin
            if (na == 0 && nb == 0)
                r.flags.is_coincident = 1'b1;
            else
                r.flags.is_parallel = 1'b1;
        end
        else if (in_unit(na, den) && in_unit(nb, den))
        begin
            r.flags.is_intersecting = 1'b1;
            r.cross_x = clamp32((ax1 <<< FRAC) + scaled_offset(na, dax, den));
            r.cross_y = clamp32((ay1 <<< FRAC) + scaled_offset(na, day, den));
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("error at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
        error_count++;
    endtask

    // send one segment pair, then maybe leave a gap
    task automatic send_pair(coord_t pt[8]);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pt[7], pt[6], pt[5], pt[4], pt[3], pt[2], pt[1], pt[0]};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_crossings.push_back(predict_crossing(pt));
        if ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4)) @(negedge clk);
        end
    endtask

    task automatic send_coords(int c0, int c1, int c2, int c3, int c4, int c5, int c6, int c7);
        coord_t pt[8];
        pt[0] = coord_t'(c0); pt[1] = coord_t'(c1); pt[2] = coord_t'(c2); pt[3] = coord_t'(c3);
        pt[4] = coord_t'(c4); pt[5] = coord_t'(c5); pt[6] = coord_t'(c6); pt[7] = coord_t'(c7);
        send_pair(pt);
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        crossing_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("segment_intersection: mismatch");
            $finish;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_crossings.size() == 0)
                report_mismatch("beat with nothing expected, tdata low",
                    longint'(m_axis_tdata[63:0]), 0);
            else
            begin
                want = pending_crossings.pop_front();
                if (m_axis_tdata[0] !== want.flags.is_parallel)
                    report_mismatch("is_parallel", longint'(m_axis_tdata[0]),
                        longint'(want.flags.is_parallel));
                if (m_axis_tdata[1] !== want.flags.is_coincident)
                    report_mismatch("is_coincident", longint'(m_axis_tdata[1]),
                        longint'(want.flags.is_coincident));
                if (m_axis_tdata[2] !== want.flags.is_intersecting)
                    report_mismatch("is_intersecting", longint'(m_axis_tdata[2]),
                        longint'(want.flags.is_intersecting));
                if (m_axis_tdata[34:3] !== want.cross_x)
                    report_mismatch("cross_x", longint'($signed(m_axis_tdata[34:3])),
                        longint'(want.cross_x));
                if (m_axis_tdata[66:35] !== want.cross_y)
                    report_mismatch("cross_y", longint'($signed(m_axis_tdata[66:35])),
                        longint'(want.cross_y));
            end
        end
    end

    task automatic test_extremes();
        send_coords(0, 0, 0, 0, 0, 0, 0, 0);
        send_coords(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        send_coords(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768);
        send_coords(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
        send_coords(-32768, -32768, -32768, 32767, 32767, -32768, 32767, 32767);
        send_coords(-1, -1, -1, -1, -1, -1, -1, -1);
        send_coords(32767, 32767, -32768, -32768, -32768, -32768, 32767, 32767);
    endtask

    task automatic test_special_cases();
        send_coords(0, 0, 10, 10, 0, 10, 10, 0);      // plain crossing
        send_coords(0, 10, 10, 0, 0, 0, 10, 10);      // swapped segments, positive denominator
        send_coords(0, 0, 10, 0, 10, 0, 10, 10);      // touching at parameter one
        send_coords(0, 0, 10, 0, 0, 0, 0, 10);        // touching at parameter zero
        send_coords(0, 0, 10, 0, 0, 5, 10, 5);        // parallel
        send_coords(0, 0, 10, 0, 5, 0, 20, 0);        // coincident
        send_coords(0, 0, 10, 0, 20, 0, 30, 0);       // collinear, disjoint
        send_coords(3, 4, 3, 4, 0, 0, 10, 10);        // degenerate first segment
        send_coords(0, 0, 10, 10, 7, 7, 7, 7);        // degenerate second segment
        send_coords(5, 5, 5, 5, 5, 5, 5, 5);          // both degenerate
        send_coords(0, 0, 10, 0, 20, -5, 20, 5);      // lines cross outside
        send_coords(0, 0, 3, 7, 0, 5, 3, 1);          // fractional point
        send_coords(-7, 3, 2, -9, -8, -8, 5, 6);
    endtask

    function automatic int rnd_signed(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    task automatic test_random(int count, int send_pct, int recv_pct);
        coord_t pt[8];
        int px, py, ux, uy, vx, vy, k, m;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count)
        begin
            px = rnd_signed(20000); py = rnd_signed(20000);
            ux = rnd_signed(2000);  uy = rnd_signed(2000);
            vx = rnd_signed(2000);  vy = rnd_signed(2000);
            case ($urandom_range(9))
                0, 1:
                    for (int i = 0; i < 8; i++)
                        pt[i] = coord_t'($urandom);
                2, 3:
                    for (int i = 0; i < 8; i++)
                        pt[i] = coord_t'(rnd_signed(40));
                4, 5, 6:
                begin
                    // both segments pass near a shared point
                    k = rnd_signed(3);
                    pt[0] = coord_t'(px - ux); pt[1] = coord_t'(py - uy);
                    pt[2] = coord_t'(px + ux); pt[3] = coord_t'(py + uy);
                    pt[4] = coord_t'(px - vx + k); pt[5] = coord_t'(py - vy);
                    pt[6] = coord_t'(px + vx); pt[7] = coord_t'(py + vy - k);
                end
                7:
                begin
                    // parallel copy
                    k = rnd_signed(2);
                    pt[0] = coord_t'(px); pt[1] = coord_t'(py);
                    pt[2] = coord_t'(px + ux); pt[3] = coord_t'(py + uy);
                    pt[4] = coord_t'(px + vx); pt[5] = coord_t'(py + vy);
                    pt[6] = coord_t'(px + vx + ux * k); pt[7] = coord_t'(py + vy + uy * k);
                end
                8:
                begin
                    // same line
                    ux = rnd_signed(500); uy = rnd_signed(500);
                    k = rnd_signed(3); m = rnd_signed(3);
                    pt[0] = coord_t'(px); pt[1] = coord_t'(py);
                    pt[2] = coord_t'(px + ux); pt[3] = coord_t'(py + uy);
                    pt[4] = coord_t'(px + k * ux); pt[5] = coord_t'(py + k * uy);
                    pt[6] = coord_t'(px + m * ux); pt[7] = coord_t'(py + m * uy);
                end
                default:
                begin
                    for (int i = 0; i < 8; i++)
                        pt[i] = coord_t'(rnd_signed(3000));
                    if ($urandom_range(1))
                    begin
                        pt[2] = pt[0]; pt[3] = pt[1];
                    end
                    else
                    begin
                        pt[6] = pt[4]; pt[7] = pt[5];
                    end
                end
            endcase
            send_pair(pt);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        send_idle_pct = 16;
        recv_idle_pct = 63;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_extremes();
        test_special_cases();
        test_random(450, 16, 63);
        test_random(450, 63, 16);
        test_random(450, 0, 0);

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_crossings.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (error_count == 0)
            $display("segment_intersection: match");
        else
            $display("segment_intersection: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
